FILE: rtl/core/lpc_pkg.sv
// shared types, constants and angle table for the lidar polar-to-cartesian core
`default_nettype none
package lpc_pkg;

	// number of rotation cells in the cordic chain (8 to 30)
	localparam int CORDIC_STAGES = 16;

	localparam int RANGE_W = 24;
	localparam int ANGLE_W = 32;
	localparam int COORD_W = 32;
	localparam int CFG_W   = 32;
	localparam int IDX_W   = 3;
	localparam int MAG_W   = 32;
	localparam int SHIFT_W = 5;

	// 0.1 m in Q8.16
	localparam logic [RANGE_W-1:0] RANGE_MARGIN = 24'd6554;
	// cordic gain compensation in Q2.30
	localparam logic signed [COORD_W-1:0] CORDIC_GAIN = 32'sd652032874;

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_START_ANGLE = 3'd0,
		REG_ANGLE_STEP  = 3'd1,
		REG_MIN_RANGE   = 3'd2,
		REG_MAX_RANGE   = 3'd3,
		REG_MAP_SCALE   = 3'd4
	} reg_idx_t;

	// data handed from one cordic cell to the next
	typedef struct packed {
		logic                        valid;
		logic                        flip;
		logic [MAG_W-1:0]            mag;
		logic signed [COORD_W-1:0]   x;
		logic signed [COORD_W-1:0]   y;
		logic signed [ANGLE_W-1:0]   z;
	} cell_t;

	// atan(2^-i) as a binary angle, full turn is 2^32
	function automatic logic signed [ANGLE_W-1:0] atan_angle(input logic [SHIFT_W-1:0] i);
		logic signed [ANGLE_W-1:0] a;
		case (i)
			5'd0:  a = 32'sd536870912;
			5'd1:  a = 32'sd316933406;
			5'd2:  a = 32'sd167458907;
			5'd3:  a = 32'sd85004756;
			5'd4:  a = 32'sd42667331;
			5'd5:  a = 32'sd21354465;
			5'd6:  a = 32'sd10679838;
			5'd7:  a = 32'sd5340245;
			5'd8:  a = 32'sd2670163;
			5'd9:  a = 32'sd1335087;
			5'd10: a = 32'sd667544;
			5'd11: a = 32'sd333772;
			5'd12: a = 32'sd166886;
			5'd13: a = 32'sd83443;
			5'd14: a = 32'sd41722;
			5'd15: a = 32'sd20861;
			5'd16: a = 32'sd10430;
			5'd17: a = 32'sd5215;
			5'd18: a = 32'sd2608;
			5'd19: a = 32'sd1304;
			5'd20: a = 32'sd652;
			5'd21: a = 32'sd326;
			5'd22: a = 32'sd163;
			5'd23: a = 32'sd81;
			5'd24: a = 32'sd41;
			5'd25: a = 32'sd20;
			5'd26: a = 32'sd10;
			5'd27: a = 32'sd5;
			5'd28: a = 32'sd3;
			5'd29: a = 32'sd1;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/lpc_front.sv
// beam angle tracking, range gating, map scaling and cordic seed
`default_nettype none
module lpc_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           adv,
	input  wire logic                           in_valid,
	input  wire logic [lpc_pkg::RANGE_W-1:0]    range_sample,
	input  wire logic                           first_of_scan,
	input  wire logic [lpc_pkg::ANGLE_W-1:0]    start_angle,
	input  wire logic [lpc_pkg::ANGLE_W-1:0]    angle_step,
	input  wire logic [lpc_pkg::RANGE_W-1:0]    min_range,
	input  wire logic [lpc_pkg::RANGE_W-1:0]    max_range,
	input  wire logic [lpc_pkg::RANGE_W-1:0]    map_scale,
	output lpc_pkg::cell_t                      seed
);

	logic [lpc_pkg::ANGLE_W-1:0] beam_angle_q;
	logic [lpc_pkg::ANGLE_W-1:0] angle_next;
	logic                        keep;
	logic                        accept;

	logic                        valid_s1;
	logic [lpc_pkg::RANGE_W-1:0] range_s1;
	logic [lpc_pkg::ANGLE_W-1:0] angle_s1;

	logic [2*lpc_pkg::RANGE_W-1:0] scaled;
	logic [lpc_pkg::ANGLE_W-1:0]   angle_rot;
	logic                          flip;
	lpc_pkg::cell_t                seed_s2;

	assign accept = in_valid && adv;

	// next beam angle and range window
	always_comb begin
		angle_next = first_of_scan ? start_angle : beam_angle_q + angle_step;
		keep = (range_sample > min_range) &&
			(({1'b0, range_sample} + {1'b0, lpc_pkg::RANGE_MARGIN}) < {1'b0, max_range});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_angle_q <= '0;
		end else if (accept) begin
			beam_angle_q <= angle_next;
		end
	end

	// first stage: sample and its angle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			range_s1 <= range_sample;
			angle_s1 <= angle_next;
		end
	end

	// scale to map units and fold the angle into the right half plane
	always_comb begin
		scaled    = (range_s1 * map_scale) + 48'h8000;
		flip      = angle_s1[31] ^ angle_s1[30];
		angle_rot = flip ? angle_s1 + 32'h8000_0000 : angle_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_s2 <= '0;
		end else if (adv) begin
			seed_s2.valid <= valid_s1;
			seed_s2.flip  <= flip;
			seed_s2.mag   <= scaled[2*lpc_pkg::RANGE_W-1:16];
			seed_s2.x     <= lpc_pkg::CORDIC_GAIN;
			seed_s2.y     <= '0;
			seed_s2.z     <= $signed(angle_rot);
		end
	end

	assign seed = seed_s2;

endmodule
`default_nettype wire

FILE: rtl/core/lpc_cordic_cell.sv
// one rotation cell of the cordic chain
`default_nettype none
module lpc_cordic_cell (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          adv,
	input  wire logic [lpc_pkg::SHIFT_W-1:0]   stage_idx,
	input  lpc_pkg::cell_t                     prev,
	output lpc_pkg::cell_t                     next
);

	lpc_pkg::cell_t             cell_q;
	logic signed [lpc_pkg::COORD_W-1:0] x_sh;
	logic signed [lpc_pkg::COORD_W-1:0] y_sh;
	logic signed [lpc_pkg::ANGLE_W-1:0] step;

	// rotate toward the residual angle
	always_comb begin
		x_sh = prev.x >>> stage_idx;
		y_sh = prev.y >>> stage_idx;
		step = lpc_pkg::atan_angle(stage_idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else if (adv) begin
			cell_q.valid <= prev.valid;
			cell_q.flip  <= prev.flip;
			cell_q.mag   <= prev.mag;
			if (prev.z >= 0) begin
				cell_q.x <= prev.x - y_sh;
				cell_q.y <= prev.y + x_sh;
				cell_q.z <= prev.z - step;
			end else begin
				cell_q.x <= prev.x + y_sh;
				cell_q.y <= prev.y - x_sh;
				cell_q.z <= prev.z + step;
			end
		end
	end

	assign next = cell_q;

endmodule
`default_nettype wire

FILE: rtl/core/lpc_product.sv
// range times cosine and sine, rounding, saturation and output register
`default_nettype none
module lpc_product (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              adv,
	input  lpc_pkg::cell_t                         last,
	output logic                                   res_valid,
	output logic signed [lpc_pkg::COORD_W-1:0]     res_x,
	output logic signed [lpc_pkg::COORD_W-1:0]     res_y
);

	localparam int PW = lpc_pkg::COORD_W + 17;
	localparam int SW = lpc_pkg::COORD_W + 34;

	logic signed [lpc_pkg::COORD_W-1:0] cx;
	logic signed [lpc_pkg::COORD_W-1:0] cy;
	logic signed [PW-1:0] cx_e;
	logic signed [PW-1:0] cy_e;
	logic signed [PW-1:0] mlo_e;
	logic signed [PW-1:0] mhi_e;

	logic                 valid_s1;
	logic signed [PW-1:0] xlo_s1;
	logic signed [PW-1:0] xhi_s1;
	logic signed [PW-1:0] ylo_s1;
	logic signed [PW-1:0] yhi_s1;

	logic signed [SW-1:0] xsum;
	logic signed [SW-1:0] ysum;
	logic signed [SW-1:0] xsh;
	logic signed [SW-1:0] ysh;

	logic                              valid_q;
	logic signed [lpc_pkg::COORD_W-1:0] x_q;
	logic signed [lpc_pkg::COORD_W-1:0] y_q;

	// undo the half turn and split the magnitude in two 16 bit halves
	always_comb begin
		cx    = last.flip ? -last.x : last.x;
		cy    = last.flip ? -last.y : last.y;
		cx_e  = PW'(cx);
		cy_e  = PW'(cy);
		mlo_e = $signed(PW'(last.mag[15:0]));
		mhi_e = $signed(PW'(last.mag[31:16]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xlo_s1 <= mlo_e * cx_e;
			xhi_s1 <= mhi_e * cx_e;
			ylo_s1 <= mlo_e * cy_e;
			yhi_s1 <= mhi_e * cy_e;
		end
	end

	// combine partial products and round Q16.46 to Q16.16
	always_comb begin
		xsum = (SW'(xhi_s1) <<< 16) + SW'(xlo_s1) + (SW'(1) <<< 29);
		ysum = (SW'(yhi_s1) <<< 16) + SW'(ylo_s1) + (SW'(1) <<< 29);
		xsh  = xsum >>> 30;
		ysh  = ysum >>> 30;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_s1;
		end
	end

	// saturate to the signed 32 bit range
	always_ff @(posedge clk) begin
		if (adv) begin
			if (xsh > SW'(32'sh7FFF_FFFF)) begin
				x_q <= 32'sh7FFF_FFFF;
			end else if (xsh < SW'(32'sh8000_0000)) begin
				x_q <= 32'sh8000_0000;
			end else begin
				x_q <= xsh[lpc_pkg::COORD_W-1:0];
			end
			if (ysh > SW'(32'sh7FFF_FFFF)) begin
				y_q <= 32'sh7FFF_FFFF;
			end else if (ysh < SW'(32'sh8000_0000)) begin
				y_q <= 32'sh8000_0000;
			end else begin
				y_q <= ysh[lpc_pkg::COORD_W-1:0];
			end
		end
	end

	assign res_valid = valid_q;
	assign res_x     = x_q;
	assign res_y     = y_q;

endmodule
`default_nettype wire

FILE: rtl/core/lidar_polar_to_cartesian_core.sv
// top level of the lidar polar-to-cartesian core
//
//   channel   signals                               moves
//   in        in_valid in_ready                     range_sample, first_of_scan
//   out       out_valid out_ready                   x_coord, y_coord
//   cfg       cfg_wr_en cfg_index                   cfg_data into the register file
//
// one transaction enters per cycle unless the chain stalls; from input to output it
// passes the front stages, the cordic cell chain and the two product stages.
// samples outside the range window give no output transaction.
// a full output register with out_ready low stalls the whole chain and drops in_ready.
// reset clears the valid bits, the beam angle and the registers to their defaults.
`default_nettype none
module lidar_polar_to_cartesian_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [lpc_pkg::RANGE_W-1:0]         range_sample,
	input  wire logic                                first_of_scan,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [lpc_pkg::COORD_W-1:0]       x_coord,
	output logic signed [lpc_pkg::COORD_W-1:0]       y_coord,
	input  wire logic                                cfg_wr_en,
	input  wire logic [lpc_pkg::IDX_W-1:0]           cfg_index,
	input  wire logic [lpc_pkg::CFG_W-1:0]           cfg_data
);

	logic [lpc_pkg::ANGLE_W-1:0] start_angle_q;
	logic [lpc_pkg::ANGLE_W-1:0] angle_step_q;
	logic [lpc_pkg::RANGE_W-1:0] min_range_q;
	logic [lpc_pkg::RANGE_W-1:0] max_range_q;
	logic [lpc_pkg::RANGE_W-1:0] map_scale_q;

	logic           adv;
	lpc_pkg::cell_t chain [lpc_pkg::CORDIC_STAGES+1];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_angle_q <= 32'h8000_0000;
			angle_step_q  <= 32'd11930465;
			min_range_q   <= 24'd0;
			max_range_q   <= 24'd1966080;
			map_scale_q   <= 24'd1310720;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				lpc_pkg::REG_START_ANGLE: start_angle_q <= cfg_data;
				lpc_pkg::REG_ANGLE_STEP:  angle_step_q  <= cfg_data;
				lpc_pkg::REG_MIN_RANGE:   min_range_q   <= cfg_data[lpc_pkg::RANGE_W-1:0];
				lpc_pkg::REG_MAX_RANGE:   max_range_q   <= cfg_data[lpc_pkg::RANGE_W-1:0];
				lpc_pkg::REG_MAP_SCALE:   map_scale_q   <= cfg_data[lpc_pkg::RANGE_W-1:0];
				default: ;
			endcase
		end
	end

	// the chain moves whenever the output register can take a transaction
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	lpc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.in_valid      (in_valid),
		.range_sample  (range_sample),
		.first_of_scan (first_of_scan),
		.start_angle   (start_angle_q),
		.angle_step    (angle_step_q),
		.min_range     (min_range_q),
		.max_range     (max_range_q),
		.map_scale     (map_scale_q),
		.seed          (chain[0])
	);

	// cordic rotation cells
	for (genvar i = 0; i < lpc_pkg::CORDIC_STAGES; i++) begin : g_cell
		lpc_cordic_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.stage_idx (lpc_pkg::SHIFT_W'(i)),
			.prev      (chain[i]),
			.next      (chain[i+1])
		);
	end

	lpc_product u_product (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.last      (chain[lpc_pkg::CORDIC_STAGES]),
		.res_valid (out_valid),
		.res_x     (x_coord),
		.res_y     (y_coord)
	);

endmodule
`default_nettype wire

FILE: sim/lidar_polar_to_cartesian_core_tb.sv
// testbench for the lidar polar-to-cartesian core: directed corners, then random scans
`default_nettype none
module lidar_polar_to_cartesian_core_tb;

	localparam int CLK_HALF   = 4;
	localparam int LATENCY    = lpc_pkg::CORDIC_STAGES + 4;
	localparam int REG_COUNT  = 5;
	localparam int PHASE_ITEMS = 200;

	// atan(2^-i) in binary angle units, full turn is 2^32
	localparam longint ATAN_STEPS [0:29] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1
	};

	typedef struct packed {
		logic signed [lpc_pkg::COORD_W-1:0] x;
		logic signed [lpc_pkg::COORD_W-1:0] y;
	} point_t;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 in_valid;
	logic                                 in_ready;
	logic [lpc_pkg::RANGE_W-1:0]          range_sample;
	logic                                 first_of_scan;
	logic                                 out_valid;
	logic                                 out_ready;
	logic signed [lpc_pkg::COORD_W-1:0]   x_coord;
	logic signed [lpc_pkg::COORD_W-1:0]   y_coord;
	logic                                 cfg_wr_en;
	logic [lpc_pkg::IDX_W-1:0]            cfg_index;
	logic [lpc_pkg::CFG_W-1:0]            cfg_data;

	// predictor copy of the registers and the running beam angle
	logic [31:0]                  start_angle_q;
	logic [31:0]                  angle_step_q;
	logic [lpc_pkg::RANGE_W-1:0]  min_range_q;
	logic [lpc_pkg::RANGE_W-1:0]  max_range_q;
	logic [lpc_pkg::RANGE_W-1:0]  map_scale_q;
	logic [31:0]                  beam_angle_q;

	point_t expected_points[$];
	int     mismatch_count;
	int     send_idle_pct;
	int     stall_pct;

	lidar_polar_to_cartesian_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.range_sample  (range_sample),
		.first_of_scan (first_of_scan),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.x_coord       (x_coord),
		.y_coord       (y_coord),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// clock
	always #CLK_HALF clk = ~clk;

	// receiver back-pressure
	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= stall_pct);
	end

	// clamp a Q16.16 value to the signed coordinate range
	function automatic logic signed [lpc_pkg::COORD_W-1:0] clamp_coord(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[lpc_pkg::COORD_W-1:0];
	endfunction

	// advance the beam angle and convert one sample; returns 1 when a point is produced
	function automatic bit project_beam(input logic [lpc_pkg::RANGE_W-1:0] meas,
			input logic first, output point_t pt);
		longint z, cx, cy, nx, mag, limit;
		logic [31:0] u;
		bit flip;
		pt = '0;
		if (first)
			beam_angle_q = start_angle_q;
		else
			beam_angle_q = beam_angle_q + angle_step_q;
		limit = longint'(max_range_q) - longint'(lpc_pkg::RANGE_MARGIN);
		if (!(meas > min_range_q && longint'(meas) < limit))
			return 0;
		mag = (longint'(meas) * longint'(map_scale_q) + 64'sd32768) >>> 16;
		u = beam_angle_q;
		// beams in the back half are rotated by half a turn and negated afterwards
		flip = (u[31:30] == 2'b01) || (u[31:30] == 2'b10);
		if (flip)
			u = u + 32'h80000000;
		z = longint'($signed(u));
		cx = longint'(lpc_pkg::CORDIC_GAIN);
		cy = 0;
		for (int i = 0; i < lpc_pkg::CORDIC_STAGES && i < 30; i++) begin
			if (z >= 0) begin
				nx = cx - (cy >>> i);
				cy = cy + (cx >>> i);
				z  = z - ATAN_STEPS[i];
			end else begin
				nx = cx + (cy >>> i);
				cy = cy - (cx >>> i);
				z  = z + ATAN_STEPS[i];
			end
			cx = nx;
		end
		if (flip) begin
			cx = -cx;
			cy = -cy;
		end
		pt.x = clamp_coord((mag * cx + (64'sd1 <<< 29)) >>> 30);
		pt.y = clamp_coord((mag * cy + (64'sd1 <<< 29)) >>> 30);
		return 1;
	endfunction

	// one register write, mirrored into the predictor
	task automatic write_register(input logic [lpc_pkg::IDX_W-1:0] idx,
			input logic [lpc_pkg::CFG_W-1:0] value);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		case (idx)
			lpc_pkg::REG_START_ANGLE: start_angle_q = value;
			lpc_pkg::REG_ANGLE_STEP:  angle_step_q  = value;
			lpc_pkg::REG_MIN_RANGE:   min_range_q   = value[lpc_pkg::RANGE_W-1:0];
			lpc_pkg::REG_MAX_RANGE:   max_range_q   = value[lpc_pkg::RANGE_W-1:0];
			lpc_pkg::REG_MAP_SCALE:   map_scale_q   = value[lpc_pkg::RANGE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// send one sample transaction, with a random idle gap in front of it
	task automatic send_sample(input logic [lpc_pkg::RANGE_W-1:0] meas, input logic first);
		point_t pt;
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid      = 1'b1;
		range_sample  = meas;
		first_of_scan = first;
		do
			@(posedge clk);
		while (!in_ready);
		if (project_beam(meas, first, pt))
			expected_points.push_back(pt);
	endtask

	// stop sending, let every expected point arrive and the pipeline empty
	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_points.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	// output check against the oldest expected point
	always @(posedge clk) begin
		point_t exp_pt;
		if (arst_n && out_valid && out_ready) begin
			if (expected_points.size() == 0) begin
				$error("unexpected output transaction x_coord=%0d y_coord=%0d", x_coord, y_coord);
				mismatch_count++;
			end else begin
				exp_pt = expected_points.pop_front();
				if (x_coord !== exp_pt.x) begin
					$error("x_coord mismatch: expected %0d, got %0d", exp_pt.x, x_coord);
					mismatch_count++;
				end
				if (y_coord !== exp_pt.y) begin
					$error("y_coord mismatch: expected %0d, got %0d", exp_pt.y, y_coord);
					mismatch_count++;
				end
			end
		end
	end

	// reset defaults, no scan start seen yet so the angle counts from zero
	task automatic test_reset_defaults();
		send_sample(24'd0, 1'b0);
		send_sample(24'd1, 1'b0);
		send_sample(max_range_q - lpc_pkg::RANGE_MARGIN - 24'd1, 1'b0);
		send_sample(max_range_q - lpc_pkg::RANGE_MARGIN, 1'b0);
		wait_idle();
	endtask

	// edges of the range window
	task automatic test_range_window();
		write_register(lpc_pkg::REG_MIN_RANGE, 32'h0001_0000);
		write_register(lpc_pkg::REG_MAX_RANGE, 32'h000a_0000);
		send_sample(min_range_q, 1'b1);
		send_sample(min_range_q + 24'd1, 1'b0);
		send_sample(max_range_q - lpc_pkg::RANGE_MARGIN - 24'd1, 1'b0);
		send_sample(max_range_q - lpc_pkg::RANGE_MARGIN, 1'b0);
		wait_idle();
	endtask

	// angles on both sides of each quadrant boundary, including the wrap
	task automatic test_quadrant_edges();
		logic [31:0] starts [4] = '{32'h3fffffff, 32'h7fffffff, 32'hbfffffff, 32'hffffffff};
		write_register(lpc_pkg::REG_MIN_RANGE, 32'd0);
		write_register(lpc_pkg::REG_ANGLE_STEP, 32'd1);
		foreach (starts[k]) begin
			write_register(lpc_pkg::REG_START_ANGLE, starts[k]);
			send_sample(24'h05_0000, 1'b1);
			send_sample(24'h05_0000, 1'b0);
			wait_idle();
		end
	endtask

	// largest range and scale on each axis drive both coordinates into saturation
	task automatic test_saturation();
		write_register(lpc_pkg::REG_MAX_RANGE, 32'h00ff_ffff);
		write_register(lpc_pkg::REG_MAP_SCALE, 32'h00ff_ffff);
		write_register(lpc_pkg::REG_START_ANGLE, 32'h0);
		write_register(lpc_pkg::REG_ANGLE_STEP, 32'h4000_0000);
		send_sample(24'hffffff - lpc_pkg::RANGE_MARGIN - 24'd1, 1'b1);
		send_sample(24'hffffff - lpc_pkg::RANGE_MARGIN - 24'd1, 1'b0);
		send_sample(24'hffffff, 1'b0);
		send_sample(24'hffffff - lpc_pkg::RANGE_MARGIN - 24'd1, 1'b0);
		wait_idle();
	endtask

	// max range below the margin drops everything
	task automatic test_narrow_max();
		write_register(lpc_pkg::REG_MAX_RANGE, 32'd0);
		send_sample(24'h00_8000, 1'b0);
		wait_idle();
		write_register(lpc_pkg::REG_MAX_RANGE, 32'(lpc_pkg::RANGE_MARGIN) - 32'd1);
		send_sample(24'd1, 1'b0);
		wait_idle();
	endtask

	// zero scale gives the origin for kept samples
	task automatic test_zero_scale();
		write_register(lpc_pkg::REG_MAX_RANGE, 32'h00ff_ffff);
		write_register(lpc_pkg::REG_MAP_SCALE, 32'd0);
		send_sample(24'h12_3456, 1'b1);
		send_sample(24'hfe_0000, 1'b0);
		wait_idle();
	endtask

	// writes to indexes past the register list change nothing
	task automatic test_unused_index();
		write_register(lpc_pkg::REG_MAP_SCALE, 32'h0001_8000);
		for (int idx = REG_COUNT; idx < (1 << lpc_pkg::IDX_W); idx++)
			write_register(lpc_pkg::IDX_W'(idx), 32'hffff_ffff);
		send_sample(24'h03_0000, 1'b1);
		send_sample(24'h07_0000, 1'b0);
		wait_idle();
	endtask

	// pick a sample biased toward the kept window and its edges
	function automatic logic [lpc_pkg::RANGE_W-1:0] pick_range();
		longint lo, hi;
		int roll;
		lo = longint'(min_range_q);
		hi = longint'(max_range_q) - longint'(lpc_pkg::RANGE_MARGIN);
		roll = $urandom_range(99);
		if (hi - lo < 2 || roll >= 85)
			return lpc_pkg::RANGE_W'($urandom);
		if (roll < 70)
			return lpc_pkg::RANGE_W'($urandom_range(32'(hi - 1), 32'(lo + 1)));
		case ($urandom_range(3))
			0: return lpc_pkg::RANGE_W'(lo);
			1: return lpc_pkg::RANGE_W'(lo + 1);
			2: return lpc_pkg::RANGE_W'(hi - 1);
			default: return lpc_pkg::RANGE_W'(hi);
		endcase
	endfunction

	// random scans under one idling mode and one register setting
	task automatic test_random_scans(input int send_pct, input int stall_p, input int flavor);
		int sent;
		int scan_len;
		logic first;
		logic [lpc_pkg::RANGE_W-1:0] mx, mn;
		wait_idle();
		case (flavor)
			0: begin
				mn = 24'd0;
				mx = 24'hffffff;
				write_register(lpc_pkg::REG_START_ANGLE, $urandom);
				write_register(lpc_pkg::REG_ANGLE_STEP, $urandom_range(32'h0100_0000));
				write_register(lpc_pkg::REG_MAP_SCALE, 32'h00ff_ffff);
			end
			1: begin
				mn = lpc_pkg::RANGE_W'($urandom_range(32'h0004_0000));
				mx = mn + lpc_pkg::RANGE_W'($urandom_range(32'h00c0_0000, 32'h0001_0000));
				write_register(lpc_pkg::REG_START_ANGLE, 32'h8000_0000);
				write_register(lpc_pkg::REG_ANGLE_STEP, 32'h7fff_ffff);
				write_register(lpc_pkg::REG_MAP_SCALE, $urandom_range(32'h00ff_ffff));
			end
			2: begin
				mn = lpc_pkg::RANGE_W'($urandom_range(32'h0001_0000));
				mx = 24'h1e_0000;
				write_register(lpc_pkg::REG_START_ANGLE, 32'h7fff_ffff);
				write_register(lpc_pkg::REG_ANGLE_STEP, 32'h8000_0000);
				write_register(lpc_pkg::REG_MAP_SCALE, 32'h0000_0001);
			end
			default: begin
				mn = lpc_pkg::RANGE_W'($urandom_range(32'h0000_8000));
				mx = lpc_pkg::RANGE_W'($urandom_range(32'h00ff_ffff, 32'h0010_0000));
				write_register(lpc_pkg::REG_START_ANGLE, $urandom);
				write_register(lpc_pkg::REG_ANGLE_STEP, $urandom);
				write_register(lpc_pkg::REG_MAP_SCALE, $urandom_range(32'h0014_0000));
			end
		endcase
		write_register(lpc_pkg::REG_MIN_RANGE, 32'(mn));
		write_register(lpc_pkg::REG_MAX_RANGE, 32'(mx));
		send_idle_pct = send_pct;
		stall_pct     = stall_p;
		sent = 0;
		while (sent < PHASE_ITEMS) begin
			scan_len = $urandom_range(48, 1);
			for (int k = 0; k < scan_len && sent < PHASE_ITEMS; k++) begin
				first = (k == 0);
				// occasional stray or missing scan marker
				if ($urandom_range(99) < 8)
					first = 1'($urandom_range(1));
				send_sample(pick_range(), first);
				sent++;
			end
		end
		wait_idle();
		send_idle_pct = 0;
		stall_pct     = 0;
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		range_sample   = '0;
		first_of_scan  = 1'b0;
		out_ready      = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		mismatch_count = 0;
		send_idle_pct  = 0;
		stall_pct      = 0;
		start_angle_q  = 32'h8000_0000;
		angle_step_q   = 32'd11930465;
		min_range_q    = '0;
		max_range_q    = 24'd1966080;
		map_scale_q    = 24'd1310720;
		beam_angle_q   = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_range_window();
		test_quadrant_edges();
		test_saturation();
		test_narrow_max();
		test_zero_scale();
		test_unused_index();
		test_random_scans(0, 0, 0);
		test_random_scans(86, 0, 1);
		test_random_scans(0, 86, 2);
		test_random_scans(16, 16, 3);

		wait_idle();
		if (mismatch_count == 0)
			$display("lidar_polar_to_cartesian_core test passed");
		else
			$display("lidar_polar_to_cartesian_core test failed");
		$finish;
	end

	// overall time limit
	initial begin
		#(2 * CLK_HALF * 600000);
		$display("lidar_polar_to_cartesian_core test failed");
		$finish;
	end

endmodule
`default_nettype wire

FILE: sim.f
rtl/core/lpc_pkg.sv
rtl/core/lpc_front.sv
rtl/core/lpc_cordic_cell.sv
rtl/core/lpc_product.sv
rtl/core/lidar_polar_to_cartesian_core.sv
sim/lidar_polar_to_cartesian_core_tb.sv
